>>> src/jsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// shared widths, codes and state type for the jacobi symbol unit
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int JSU_W     = 32;
	localparam int JSU_CNT_W = $clog2(JSU_W);

	// n mod 8 residues for which (2/n) is -1
	localparam logic [2:0] MOD8_THREE = 3'd3;
	localparam logic [2:0] MOD8_FIVE  = 3'd5;

	// both operands 3 mod 4 flips the sign under reciprocity
	localparam logic [1:0] MOD4_THREE = 2'd3;

	// smallest legal modulus
	localparam logic [JSU_W-1:0] N_MIN = JSU_W'(3);

	// symbol encodings
	localparam logic [1:0] SYM_ZERO = 2'b00;
	localparam logic [1:0] SYM_POS  = 2'b01;
	localparam logic [1:0] SYM_NEG  = 2'b11;

	// status encodings
	localparam logic STAT_OK      = 1'b0;
	localparam logic STAT_INVALID = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_OUT
	} jsu_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} jsu_rem_stat_t;

endpackage

`default_nettype wire

>>> src/jsu_rem_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_rem_unit
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module jsu_rem_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [jsu_pkg::JSU_W-1:0]  dividend,
	input  wire logic [jsu_pkg::JSU_W-1:0]  divisor,
	output jsu_pkg::jsu_rem_stat_t          rem_stat,
	output logic      [jsu_pkg::JSU_W-1:0]  remainder
);

	logic                            busy_q;
	logic                            done_q;
	logic [jsu_pkg::JSU_CNT_W-1:0]   cnt_q;
	logic [jsu_pkg::JSU_W-1:0]       rem_q;
	logic [jsu_pkg::JSU_W-1:0]       dvd_q;
	logic [jsu_pkg::JSU_W-1:0]       dvs_q;
	logic [jsu_pkg::JSU_W:0]         shifted;
	logic [jsu_pkg::JSU_W:0]         diff;
	logic [jsu_pkg::JSU_W-1:0]       rem_next;

	// partial remainder stays below the divisor, so one extra bit is enough
	always_comb begin
		shifted  = {rem_q, dvd_q[jsu_pkg::JSU_W-1]};
		diff     = shifted - {1'b0, dvs_q};
		rem_next = diff[jsu_pkg::JSU_W] ? shifted[jsu_pkg::JSU_W-1:0]
		                                : diff[jsu_pkg::JSU_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= jsu_pkg::JSU_CNT_W'(jsu_pkg::JSU_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[jsu_pkg::JSU_W-2:0], 1'b0};
		end
	end

	assign rem_stat.busy = busy_q;
	assign rem_stat.done = done_q;
	assign remainder     = rem_q;

endmodule

`default_nettype wire

>>> src/jacobi_symbol_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_symbol_unit
// computes the jacobi symbol (a/n) with a binary-euclid sequencer
// ----------------------------------------------------------------------------
// usage
//   input channel: a_value and n_value, a transaction completes when in_valid
//   is high and in_stall is low. in_stall stays high from the cycle after a
//   transaction until its result has been moved into the output register.
//   output channel: symbol (-1, 0, 1 as 2-bit two's complement) and status
//   (1 marks invalid input, symbol then 0), held while out_stall is high.
// sequence
//   invalid inputs: from the check state straight to the output state.
//   valid inputs: a check step per factor of two removed from a, and per
//   reduction step a swap in the check state, then the divide state while the
//   remainder unit runs at one quotient bit per cycle, until its done strobe.
//   the number of reduction steps follows the euclid chain of (a, n).
//   one item is in work at a time; the next input transaction can come in the
//   cycle after the result enters the output register.
// reset
//   arst_n clears the sequencer, the remainder unit and out_valid.
// stall
//   a finished result waits in the sequencer until the output register is
//   free; while it waits, the next input transaction is blocked.
// ----------------------------------------------------------------------------
module jacobi_symbol_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [jsu_pkg::JSU_W-1:0]  a_value,
	input  wire logic signed [jsu_pkg::JSU_W-1:0]  n_value,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [1:0]                      symbol,
	output logic                                   status
);

	// sequencer state
	jsu_pkg::jsu_state_t               state_q;
	jsu_pkg::jsu_state_t               state_nxt;

	// operand registers and running sign
	logic [jsu_pkg::JSU_W-1:0]         a_q;
	logic [jsu_pkg::JSU_W-1:0]         n_q;
	logic                              neg_q;
	logic                              bad_q;

	// result waiting for the output register
	logic [1:0]                        res_sym_q;
	logic                              res_stat_q;

	// output register
	logic                              out_valid_q;
	logic [1:0]                        out_sym_q;
	logic                              out_stat_q;

	// remainder unit hookup
	logic                              rem_start;
	jsu_pkg::jsu_rem_stat_t            rem_stat;
	logic [jsu_pkg::JSU_W-1:0]         rem_val;

	// control decodes
	logic                              in_take;
	logic                              out_free;
	logic                              in_bad;
	logic [jsu_pkg::JSU_W-1:0]         a_in;
	logic [jsu_pkg::JSU_W-1:0]         n_in;
	logic                              flip_two;
	logic                              flip_recip;

	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign a_in     = a_value;
	assign n_in     = n_value;

	// input checks: n negative, below 3, even; a negative or not below n
	assign in_bad = n_in[jsu_pkg::JSU_W-1] || (n_in < jsu_pkg::N_MIN) || !n_in[0] ||
	                a_in[jsu_pkg::JSU_W-1] || (a_in >= n_in);

	// (2/n) is -1 for n = 3 or 5 mod 8
	assign flip_two = (n_q[2:0] == jsu_pkg::MOD8_THREE) ||
	                  (n_q[2:0] == jsu_pkg::MOD8_FIVE);

	// reciprocity: both odd operands 3 mod 4
	assign flip_recip = (a_q[1:0] == jsu_pkg::MOD4_THREE) &&
	                    (n_q[1:0] == jsu_pkg::MOD4_THREE);

	jsu_rem_unit u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (n_q),
		.divisor   (a_q),
		.rem_stat  (rem_stat),
		.remainder (rem_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jsu_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and strobes
	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		rem_start = 1'b0;
		unique case (state_q)
			jsu_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nxt = jsu_pkg::ST_CHECK;
				end
			end
			jsu_pkg::ST_CHECK: begin
				if (bad_q || a_q == '0) begin
					state_nxt = jsu_pkg::ST_OUT;
				end else if (a_q[0]) begin
					// odd a: swap operands and reduce the new a modulo the new n
					rem_start = 1'b1;
					state_nxt = jsu_pkg::ST_DIV;
				end
			end
			jsu_pkg::ST_DIV: begin
				if (rem_stat.done) begin
					state_nxt = jsu_pkg::ST_CHECK;
				end
			end
			jsu_pkg::ST_OUT: begin
				if (out_free) begin
					state_nxt = jsu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = jsu_pkg::ST_IDLE;
			end
		endcase
	end

	// operand datapath
	always_ff @(posedge clk) begin
		if (in_take) begin
			a_q   <= a_in;
			n_q   <= n_in;
			bad_q <= in_bad;
			neg_q <= 1'b0;
		end else if (state_q == jsu_pkg::ST_CHECK) begin
			if (bad_q) begin
				res_sym_q  <= jsu_pkg::SYM_ZERO;
				res_stat_q <= jsu_pkg::STAT_INVALID;
			end else if (a_q == '0) begin
				// loop done: symbol is the sign when n reached 1, else gcd > 1
				res_stat_q <= jsu_pkg::STAT_OK;
				if (n_q == jsu_pkg::JSU_W'(1)) begin
					res_sym_q <= neg_q ? jsu_pkg::SYM_NEG : jsu_pkg::SYM_POS;
				end else begin
					res_sym_q <= jsu_pkg::SYM_ZERO;
				end
			end else if (!a_q[0]) begin
				// strip one factor of two
				a_q <= {1'b0, a_q[jsu_pkg::JSU_W-1:1]};
				if (flip_two) begin
					neg_q <= !neg_q;
				end
			end else begin
				// swap; the remainder unit latches the old values at this same edge
				n_q <= a_q;
				if (flip_recip) begin
					neg_q <= !neg_q;
				end
			end
		end else if (state_q == jsu_pkg::ST_DIV && rem_stat.done) begin
			a_q <= rem_val;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == jsu_pkg::ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == jsu_pkg::ST_OUT && out_free) begin
			out_sym_q  <= res_sym_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = out_sym_q;
	assign status    = out_stat_q;

endmodule

`default_nettype wire

>>> src/jsu_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_checker
// port-level checks for the jacobi symbol unit, bound to the top level
// ----------------------------------------------------------------------------
module jsu_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic signed [jsu_pkg::JSU_W-1:0]  a_value,
	input wire logic signed [jsu_pkg::JSU_W-1:0]  n_value,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic signed [1:0]                 symbol,
	input wire logic                              status
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled input transaction stays offered with the same operands
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(a_value) && $stable(n_value))
		else $error("input payload changed while stalled");

	// one item in work: the input closes right after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction taken while busy");

	// invalid input reports a zero symbol
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> symbol == jsu_pkg::SYM_ZERO)
		else $error("invalid status with nonzero symbol");

	// the symbol is never the unused code
	a_sym_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> symbol == jsu_pkg::SYM_ZERO || symbol == jsu_pkg::SYM_POS ||
		              symbol == jsu_pkg::SYM_NEG)
		else $error("symbol out of range");

endmodule

bind jacobi_symbol_unit jsu_checker u_jsu_checker (.*);

`default_nettype wire

>>> test/tb_jacobi_symbol_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_jacobi_symbol_unit
// self-checking bench for the jacobi symbol unit
// ----------------------------------------------------------------------------
// A short directed list comes first. It covers the input checks, a zero
// numerator, each residue of n mod 8 under (2/n), the reciprocity flip,
// common factors and the widest operands. After it come random pairs: mostly
// well-formed (n odd and at least 3, a below n) with sizes spread over the
// full width, plus a share of malformed pairs. An internal predictor computes
// every symbol, and each output transaction is checked against the oldest
// prediction. Both channels idle at random. The receiver holds off once for a
// long stretch, and the sender pauses now and then until the unit is empty.
// ----------------------------------------------------------------------------
module tb_jacobi_symbol_unit;

	localparam int RANDOM_PAIRS = 1330;
	localparam int HOLD_CYCLES  = 1500;     // long receiver hold-off
	localparam int HOLD_AFTER   = 200;      // results seen before the hold-off
	localparam int TAIL_CYCLES  = 100;      // quiet time after the last result
	localparam int CYCLE_LIMIT  = 10000000; // watchdog

	typedef struct {
		logic [31:0] a;
		logic [31:0] n;
		bit          drain_first; // wait for an empty unit before offering
	} jacobi_pair_t;

	typedef struct packed {
		logic signed [1:0] symbol;
		logic              status;
	} jacobi_result_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic signed [31:0] a_value   = '0;
	logic signed [31:0] n_value   = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [1:0]  symbol;
	logic               status;

	jacobi_pair_t   pair_queue[$];       // pairs not yet offered
	jacobi_result_t expected_results[$]; // predictions waiting for their result

	bit in_taken       = 1'b0;
	bit tx_quiet       = 1'b0; // sender runs with no gaps while set
	bit rx_quiet       = 1'b0; // receiver starts no random stalls while set
	bit hold_done      = 1'b0;
	int gap_left       = 0;
	int stall_left     = 0;
	int hold_left      = 0;
	int pairs_accepted = 0;
	int results_checked = 0;
	int invalid_seen   = 0;
	int neg_seen       = 0;
	int zero_seen      = 0;
	int pos_seen       = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;

	jacobi_symbol_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.a_value   (a_value),
		.n_value   (n_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.symbol    (symbol),
		.status    (status)
	);

	// ------------------------------------------------------------------------
	// predictor: jacobi symbol by factor-of-two removal and reciprocity
	// ------------------------------------------------------------------------
	function automatic jacobi_result_t jacobi_expect(logic [31:0] a_in, logic [31:0] n_in);
		jacobi_result_t res;
		logic [31:0]    a;
		logic [31:0]    n;
		logic [31:0]    swap;
		logic           flip;
		res.symbol = jsu_pkg::SYM_ZERO;
		res.status = jsu_pkg::STAT_INVALID;
		// sign bits set, n too small or even, or a out of range
		if (n_in[31] || n_in < jsu_pkg::N_MIN || !n_in[0] || a_in[31] || a_in >= n_in)
			return res;
		a    = a_in;
		n    = n_in;
		flip = 1'b0;
		while (a != 0) begin
			// each factor of two brings in (2/n)
			while (!a[0]) begin
				a = a >> 1;
				if (n[2:0] == jsu_pkg::MOD8_THREE || n[2:0] == jsu_pkg::MOD8_FIVE)
					flip = ~flip;
			end
			swap = a;
			a    = n;
			n    = swap;
			// reciprocity: both odd parts 3 mod 4
			if (a[1:0] == jsu_pkg::MOD4_THREE && n[1:0] == jsu_pkg::MOD4_THREE)
				flip = ~flip;
			a = a % n;
		end
		res.status = jsu_pkg::STAT_OK;
		// n left above one means a common factor
		if (n == 32'd1)
			res.symbol = flip ? jsu_pkg::SYM_NEG : jsu_pkg::SYM_POS;
		return res;
	endfunction

	function automatic void queue_pair(logic [31:0] a, logic [31:0] n, bit drain);
		jacobi_pair_t p;
		p.a           = a;
		p.n           = n;
		p.drain_first = drain;
		pair_queue.push_back(p);
	endfunction

	// mostly back to back or short gaps, a few long ones
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// ------------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------------
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------------
	// input driver: offers queued pairs at the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		logic         next_valid;
		jacobi_pair_t pick;
		next_valid = in_valid;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (!in_valid || in_taken) begin
			// previous transaction done (or nothing offered): gap or next pair
			if (in_taken) begin
				gap_left = pick_gap();
				if ($urandom_range(0, 59) == 0)
					tx_quiet = ~tx_quiet;
			end
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pair_queue.size() != 0 &&
			             !(pair_queue[0].drain_first && expected_results.size() != 0)) begin
				pick    = pair_queue.pop_front();
				a_value <= pick.a;
				n_value <= pick.n;
				next_valid = 1'b1;
			end
		end
		// a stalled payload just stays where it is
		in_valid <= next_valid;
	end

	// ------------------------------------------------------------------------
	// output stall: random stalls, quiet stretches and one long hold-off
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		logic        next_stall;
		int unsigned r;
		next_stall = 1'b0;
		if ($urandom_range(0, 499) == 0)
			rx_quiet = ~rx_quiet;
		if (hold_left > 0) begin
			hold_left--;
			next_stall = 1'b1;
		end else if (!hold_done && results_checked >= HOLD_AFTER) begin
			// sender keeps going, so the unit fills up and stalls its input
			hold_done  = 1'b1;
			hold_left  = HOLD_CYCLES - 1;
			next_stall = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			next_stall = 1'b1;
		end else if (!rx_quiet) begin
			r = $urandom_range(0, 99);
			if (r >= 95) begin
				stall_left = $urandom_range(10, 60);
				next_stall = 1'b1;
			end else if (r >= 70) begin
				stall_left = $urandom_range(0, 3);
				next_stall = 1'b1;
			end
		end
		out_stall <= next_stall;
	end

	// ------------------------------------------------------------------------
	// monitor: records accepted pairs, checks each output transaction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		jacobi_result_t want;
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			expected_results.push_back(jacobi_expect(a_value, n_value));
			pairs_accepted++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with none expected: symbol %0d status %0b",
				         $time, symbol, status);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (symbol !== want.symbol || status !== want.status) begin
					mismatch_count++;
					$display("%0t: result %0d: expected symbol %0d status %0b,",
					         $time, results_checked, want.symbol, want.status,
					         " got symbol %0d status %0b", symbol, status);
				end
				if (want.status == jsu_pkg::STAT_INVALID)
					invalid_seen++;
				else if (want.symbol == jsu_pkg::SYM_NEG)
					neg_seen++;
				else if (want.symbol == jsu_pkg::SYM_POS)
					pos_seen++;
				else
					zero_seen++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: watchdog expired, %0d results still outstanding",
			         $time, expected_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		logic [31:0] a;
		logic [31:0] n;
		logic [31:0] m;
		logic [31:0] f;
		logic [31:0] mask;
		int unsigned bits;
		int unsigned kind;

		// directed: input checks, zero, (2/n) residues, reciprocity, factors
		queue_pair(32'd0, 32'd3, 1'b0);                  // zero numerator
		queue_pair(32'd1, 32'd3, 1'b0);
		queue_pair(32'd2, 32'd3, 1'b0);                  // n = 3 mod 8
		queue_pair(32'd2, 32'd5, 1'b0);                  // n = 5 mod 8
		queue_pair(32'd2, 32'd7, 1'b0);                  // n = 7 mod 8
		queue_pair(32'd2, 32'd17, 1'b0);                 // n = 1 mod 8
		queue_pair(32'd3, 32'd7, 1'b0);                  // reciprocity flip
		queue_pair(32'd3, 32'd9, 1'b0);                  // common factor
		queue_pair(32'd21, 32'd35, 1'b0);                // common factor 7
		queue_pair(32'd1, 32'd9, 1'b0);                  // square modulus
		queue_pair(32'd5, 32'd1, 1'b0);                  // n below 3
		queue_pair(32'd0, 32'd2, 1'b0);                  // n below 3 and even
		queue_pair(32'd4, 32'd8, 1'b1);                  // n even, after a drain
		queue_pair(32'd3, 32'd3, 1'b0);                  // a equal to n
		queue_pair(32'd10, 32'd3, 1'b0);                 // a above n
		queue_pair(32'hffffffff, 32'd7, 1'b0);           // a negative
		queue_pair(32'd1, 32'hfffffff9, 1'b0);           // n negative
		queue_pair(32'h80000000, 32'h7fffffff, 1'b0);    // most negative a
		queue_pair(32'h7ffffffe, 32'h7fffffff, 1'b0);    // widest legal pair
		queue_pair(32'h40000000, 32'h7fffffff, 1'b0);    // thirty factors of two
		queue_pair(32'd1134903170, 32'd1836311903, 1'b0); // longest euclid chain
		queue_pair(32'h7fffffff, 32'h7fffffff, 1'b0);    // a equal to n at the top
		queue_pair(32'hffffffff, 32'hffffffff, 1'b0);    // both all ones
		queue_pair(32'd0, 32'h7fffffff, 1'b0);

		// random: mostly well-formed pairs, sizes spread over the width
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			bits = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 16)
			                                  : $urandom_range(17, 31);
			mask = (32'd1 << bits) - 32'd1;
			n    = ($urandom & mask) | (32'd1 << (bits - 1)) | 32'd1;
			if (n < 32'd3)
				n = 32'd3;
			a    = $urandom % n;
			kind = $urandom_range(0, 99);
			if (kind < 22) begin
				// malformed pairs (the fully random case can be well-formed)
				case ($urandom_range(0, 4))
					0: begin
						a = $urandom;
						n = $urandom;
					end
					1: a = n;
					2: begin
						n = n & ~32'd1;
						a = $urandom_range(0, 3);
					end
					3: a = $urandom | 32'h80000000;
					default: begin
						n = $urandom_range(0, 1) ? ($urandom | 32'h80000000)
						                         : $urandom_range(0, 2);
						a = $urandom_range(0, 3);
					end
				endcase
			end else if (kind < 37) begin
				// shared odd factor, symbol is zero
				case ($urandom_range(0, 5))
					0: f = 32'd3;
					1: f = 32'd5;
					2: f = 32'd7;
					3: f = 32'd9;
					4: f = 32'd15;
					default: f = 32'd21;
				endcase
				m = ($urandom & ((32'd1 << $urandom_range(1, 26)) - 32'd1)) | 32'd1;
				n = f * m;
				a = f * ($urandom % m);
			end else if (kind < 50) begin
				// long runs of factors of two
				a = a & ~((32'd1 << $urandom_range(1, 12)) - 32'd1);
			end else if (kind < 62) begin
				case ($urandom_range(0, 3))
					0: a = 32'd0;
					1: a = 32'd1;
					2: a = n - 32'd1;
					default: a = n - 32'd2;
				endcase
			end
			queue_pair(a, n, (i % 450) == 449);
		end

		// everything offered and every result back
		while (pair_queue.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d pairs in, %0d results checked: %0d invalid",
		         pairs_accepted, results_checked, invalid_seen);
		$display("symbol -1/0/+1 seen %0d/%0d/%0d, random idling, one %0d-cycle hold-off",
		         neg_seen, zero_seen, pos_seen, HOLD_CYCLES);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatching results", mismatch_count);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
